[sv/pidfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pidfd_pkg;

    localparam int GAIN_W     = 16;
    localparam int TIME_W     = 16;
    localparam int LIMIT_W    = 31;
    localparam int SUM_W      = 32;
    localparam int SLOPE_W    = 32;
    localparam int DRIVE_W    = 32;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // radix-4 restoring divider: two quotient bits per cycle over a 64-bit dividend
    localparam int DIV_CYCLES = ACC_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [TIME_W-1:0] SAMPLE_PERIOD_RST = 16'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_PROP      = 3'd0,
        REG_GAIN_INTEG     = 3'd1,
        REG_GAIN_DERIV     = 3'd2,
        REG_SAMPLE_PERIOD  = 3'd3,
        REG_FILTER_TIME    = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_prop;
        logic signed [GAIN_W-1:0] gain_integ;
        logic signed [GAIN_W-1:0] gain_deriv;
        logic [TIME_W-1:0]        sample_period;
        logic [TIME_W-1:0]        filter_time;
        logic [LIMIT_W-1:0]       integral_limit;
    } cfg_t;

    typedef struct packed {
        logic load;     // capture error of the accepted beat
        logic prep;     // integral update, slope delta, tf*slope
        logic num;      // form numerator, start divider, P*error
        logic mul_a;    // hold P term, I*dt
        logic mul_i;    // integral*(I*dt)
        logic mul_b;    // hold integral term
        logic slope;    // write back filtered slope
        logic mul_d;    // D*slope
        logic sum_bc;   // integral term plus derivative term
        logic form_x;   // align and add proportional term
        logic emit;     // round, saturate, load output register
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

[sv/pidfd_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidfd_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pidfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pidfd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output pidfd_pkg::cfg_t                          cfg
);

    pidfd_pkg::cfg_t cfg_reg;
    pidfd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                pidfd_pkg::REG_GAIN_PROP: begin
                    cfg_next.gain_prop = cfg_data[pidfd_pkg::GAIN_W-1:0];
                end
                pidfd_pkg::REG_GAIN_INTEG: begin
                    cfg_next.gain_integ = cfg_data[pidfd_pkg::GAIN_W-1:0];
                end
                pidfd_pkg::REG_GAIN_DERIV: begin
                    cfg_next.gain_deriv = cfg_data[pidfd_pkg::GAIN_W-1:0];
                end
                pidfd_pkg::REG_SAMPLE_PERIOD: begin
                    cfg_next.sample_period = cfg_data[pidfd_pkg::TIME_W-1:0];
                end
                pidfd_pkg::REG_FILTER_TIME: begin
                    cfg_next.filter_time = cfg_data[pidfd_pkg::TIME_W-1:0];
                end
                pidfd_pkg::REG_INTEGRAL_LIMIT: begin
                    cfg_next.integral_limit = cfg_data[pidfd_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_prop      <= '0;
            cfg_reg.gain_integ     <= '0;
            cfg_reg.gain_deriv     <= '0;
            cfg_reg.sample_period  <= pidfd_pkg::SAMPLE_PERIOD_RST;
            cfg_reg.filter_time    <= '0;
            cfg_reg.integral_limit <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

[sv/pidfd_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidfd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    input  wire pidfd_pkg::dp_stat_t stat,
    output pidfd_pkg::dp_cmd_t       cmd
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_PREP     = 12'b0000_0000_0010,
        S_NUM      = 12'b0000_0000_0100,
        S_MUL_A    = 12'b0000_0000_1000,
        S_MUL_I    = 12'b0000_0001_0000,
        S_MUL_B    = 12'b0000_0010_0000,
        S_DIV_WAIT = 12'b0000_0100_0000,
        S_SLOPE    = 12'b0000_1000_0000,
        S_MUL_D    = 12'b0001_0000_0000,
        S_SUM_BC   = 12'b0010_0000_0000,
        S_FORM_X   = 12'b0100_0000_0000,
        S_EMIT     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.num    = 1'b1;
                state_next = S_MUL_A;
            end
            S_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = S_MUL_I;
            end
            S_MUL_I: begin
                cmd.mul_i  = 1'b1;
                state_next = S_MUL_B;
            end
            S_MUL_B: begin
                cmd.mul_b  = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = S_SLOPE;
                end
            end
            S_SLOPE: begin
                cmd.slope  = 1'b1;
                state_next = S_MUL_D;
            end
            S_MUL_D: begin
                cmd.mul_d  = 1'b1;
                state_next = S_SUM_BC;
            end
            S_SUM_BC: begin
                cmd.sum_bc = 1'b1;
                state_next = S_FORM_X;
            end
            S_FORM_X: begin
                cmd.form_x = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register has room
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

[sv/pidfd_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidfd_dp #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pidfd_pkg::cfg_t                   cfg,
    input  wire pidfd_pkg::dp_cmd_t                cmd,
    output pidfd_pkg::dp_stat_t                    stat,
    input  wire logic [DATA_WIDTH-1:0]             measured,
    input  wire logic [DATA_WIDTH-1:0]             setpoint,
    output logic [pidfd_pkg::DRIVE_W-1:0]          drive
);

    localparam int EW   = DATA_WIDTH + 1;
    localparam int MA_W = ((EW > pidfd_pkg::SUM_W) ? EW : pidfd_pkg::SUM_W) + 1;
    localparam int SW   = MA_W + 1;
    localparam int MB_W = pidfd_pkg::SUM_W + 1;
    localparam int P_W  = MA_W + MB_W;
    localparam int AW   = pidfd_pkg::ACC_W;
    localparam int XS_W = AW - 8;
    localparam logic [pidfd_pkg::DIV_CNT_W-1:0] DIV_LAST =
        pidfd_pkg::DIV_CNT_W'(pidfd_pkg::DIV_CYCLES - 1);

    // state carried across samples
    logic signed [EW-1:0]   err_reg;
    logic signed [EW-1:0]   prev_err_reg;
    logic signed [31:0]     integral_reg;
    logic signed [31:0]     slope_reg;

    // per-sample working registers
    logic signed [31:0]     delta_reg;
    logic signed [P_W-1:0]  prod_reg;
    logic signed [AW-1:0]   a_reg;
    logic signed [AW-1:0]   acc_reg;
    logic signed [AW-1:0]   bc_reg;
    logic signed [AW-1:0]   x_reg;
    logic                   inexact_reg;
    logic [31:0]            drive_reg;

    // divider
    logic [AW-1:0]                        quo_reg;
    logic [16:0]                          rem_reg;
    logic                                 div_neg_reg;
    logic                                 div_busy_reg;
    logic [pidfd_pkg::DIV_CNT_W-1:0]      div_cnt_reg;

    logic signed [EW-1:0]   err_next;
    logic signed [SW-1:0]   err_ext;
    logic signed [SW-1:0]   prev_ext;
    logic signed [SW-1:0]   int_ext;
    logic signed [SW-1:0]   isum;
    logic [31:0]            isat;
    logic signed [32:0]     s33;
    logic signed [32:0]     lim_pos;
    logic signed [32:0]     lim_neg;
    logic signed [31:0]     integral_next;
    logic signed [SW-1:0]   dsum;
    logic signed [31:0]     delta_next;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic                   mul_en;
    logic signed [AW-1:0]   prod_lo;
    logic signed [AW-1:0]   num;
    logic [AW-1:0]          num_mag;
    logic [16:0]            den;
    logic                   den_zero;
    logic [17:0]            t1;
    logic [17:0]            t2;
    logic                   ge1;
    logic                   ge2;
    logic [16:0]            r1;
    logic [16:0]            r2;
    logic [AW-1:0]          q1;
    logic [AW-1:0]          q2;
    logic [31:0]            slope_next;
    logic signed [XS_W-1:0] x_sh;
    logic signed [XS_W-1:0] res;
    logic [31:0]            drive_next;

    assign err_next = $signed({setpoint[DATA_WIDTH-1], setpoint})
                    - $signed({measured[DATA_WIDTH-1], measured});

    assign err_ext  = {{(SW-EW){err_reg[EW-1]}}, err_reg};
    assign prev_ext = {{(SW-EW){prev_err_reg[EW-1]}}, prev_err_reg};
    assign int_ext  = {{(SW-32){integral_reg[31]}}, integral_reg};

    // integral: saturate to 32 bits, then clamp to the configured magnitude unless it is zero
    always_comb begin
        isum = int_ext + err_ext;
        if ((&isum[SW-1:31]) || !(|isum[SW-1:31])) begin
            isat = isum[31:0];
        end else if (isum[SW-1]) begin
            isat = 32'h8000_0000;
        end else begin
            isat = 32'h7FFF_FFFF;
        end
        s33     = {isat[31], isat};
        lim_pos = {2'b00, cfg.integral_limit};
        lim_neg = -lim_pos;
        integral_next = isat;
        if (cfg.integral_limit != '0) begin
            if (s33 > lim_pos) begin
                integral_next = lim_pos[31:0];
            end else if (s33 < lim_neg) begin
                integral_next = lim_neg[31:0];
            end
        end
    end

    // error step, saturated to +/- 2^30
    always_comb begin
        dsum = err_ext - prev_ext;
        if ((&dsum[SW-1:30]) || !(|dsum[SW-1:30])) begin
            delta_next = dsum[31:0];
        end else if (dsum[SW-1]) begin
            delta_next = 32'hC000_0000;
        end else begin
            delta_next = 32'h4000_0000;
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.prep) begin
            mul_a = {{(MA_W-32){slope_reg[31]}}, slope_reg};
            mul_b = {{(MB_W-pidfd_pkg::TIME_W){1'b0}}, cfg.filter_time};
        end else if (cmd.num) begin
            mul_a = {{(MA_W-EW){err_reg[EW-1]}}, err_reg};
            mul_b = {{(MB_W-pidfd_pkg::GAIN_W){cfg.gain_prop[15]}}, cfg.gain_prop};
        end else if (cmd.mul_a) begin
            mul_a = {{(MA_W-pidfd_pkg::GAIN_W){cfg.gain_integ[15]}}, cfg.gain_integ};
            mul_b = {{(MB_W-pidfd_pkg::TIME_W){1'b0}}, cfg.sample_period};
        end else if (cmd.mul_i) begin
            mul_a = {{(MA_W-32){integral_reg[31]}}, integral_reg};
            mul_b = prod_reg[MB_W-1:0];
        end else if (cmd.mul_d) begin
            mul_a = {{(MA_W-32){slope_reg[31]}}, slope_reg};
            mul_b = {{(MB_W-pidfd_pkg::GAIN_W){cfg.gain_deriv[15]}}, cfg.gain_deriv};
        end
    end

    assign mul_en  = cmd.prep || cmd.num || cmd.mul_a || cmd.mul_i || cmd.mul_d;
    assign prod_lo = prod_reg[AW-1:0];

    // numerator tf*slope + delta*2^32 in sign-magnitude form
    assign num      = prod_lo + $signed({delta_reg, 32'h0000_0000});
    assign num_mag  = num[AW-1] ? AW'(-num) : AW'(num);
    assign den      = {1'b0, cfg.sample_period} + {1'b0, cfg.filter_time};
    assign den_zero = (den == '0);

    // two restoring steps per cycle
    always_comb begin
        t1  = {rem_reg, quo_reg[AW-1]};
        ge1 = (t1 >= {1'b0, den});
        r1  = ge1 ? 17'(t1 - {1'b0, den}) : t1[16:0];
        q1  = {quo_reg[AW-2:0], ge1};
        t2  = {r1, q1[AW-1]};
        ge2 = (t2 >= {1'b0, den});
        r2  = ge2 ? 17'(t2 - {1'b0, den}) : t2[16:0];
        q2  = {q1[AW-2:0], ge2};
    end

    // quotient back to signed, saturated to 32 bits
    always_comb begin
        if (div_neg_reg) begin
            if ((|quo_reg[AW-1:32]) || (quo_reg[31] && (|quo_reg[30:0]))) begin
                slope_next = 32'h8000_0000;
            end else begin
                slope_next = 32'(-quo_reg[31:0]);
            end
        end else if (|quo_reg[AW-1:31]) begin
            slope_next = 32'h7FFF_FFFF;
        end else begin
            slope_next = quo_reg[31:0];
        end
    end

    // shift out the Q.24 fraction, truncating toward zero
    always_comb begin
        x_sh = x_reg[AW-1:8];
        res  = x_sh + XS_W'(x_reg[AW-1] && (inexact_reg || (|x_reg[7:0])));
        if ((&res[XS_W-1:31]) || !(|res[XS_W-1:31])) begin
            drive_next = res[31:0];
        end else if (res[XS_W-1]) begin
            drive_next = 32'h8000_0000;
        end else begin
            drive_next = 32'h7FFF_FFFF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integral_reg <= '0;
            slope_reg    <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end else begin
            if (cmd.prep) begin
                integral_reg <= integral_next;
                prev_err_reg <= err_reg;
            end
            if (cmd.slope && !den_zero) begin
                slope_reg <= slope_next;
            end
            if (cmd.num && !den_zero) begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= '0;
            end else if (div_busy_reg) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) begin
                    div_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            err_reg <= err_next;
        end
        if (cmd.prep) begin
            delta_reg <= delta_next;
        end
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.num) begin
            quo_reg     <= num_mag;
            rem_reg     <= '0;
            div_neg_reg <= num[AW-1];
        end else if (div_busy_reg) begin
            quo_reg <= q2;
            rem_reg <= r2;
        end
        if (cmd.mul_a) begin
            a_reg <= prod_lo;
        end
        if (cmd.mul_b) begin
            acc_reg <= prod_lo;
        end
        if (cmd.sum_bc) begin
            bc_reg <= acc_reg + prod_lo;
        end
        if (cmd.form_x) begin
            x_reg       <= a_reg + (bc_reg >>> 16);
            inexact_reg <= |bc_reg[15:0];
        end
        if (cmd.emit) begin
            drive_reg <= drive_next;
        end
    end

    assign stat.div_busy = div_busy_reg;
    assign drive         = drive_reg;

endmodule

`default_nettype wire

[sv/pid_filtered_derivative_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// An accepted beat passes the prep, num, multiply, divide-wait, slope, D-multiply,
// sum and emit states on a single shared multiplier before m_tvalid; the radix-4
// slope divide is skipped when sample_period + filter_time is zero. A new beat is
// taken only in idle; a finished result waits in the output register.
// Reset: synchronous, active-low aresetn; clears integral, slope and previous error
// and loads the configuration registers with their reset values.

module pid_filtered_derivative_top #(
    parameter int DATA_WIDTH = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata: measured [DATA_WIDTH-1:0], setpoint [2*DATA_WIDTH-1:DATA_WIDTH]
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0]    s_tdata,
    // m_tdata: drive [31:0]
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [pidfd_pkg::DRIVE_W-1:0]             m_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [pidfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pidfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pidfd_pkg::cfg_t     cfg;
    pidfd_pkg::dp_cmd_t  cmd;
    pidfd_pkg::dp_stat_t stat;

    pidfd_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pidfd_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .stat     (stat),
        .measured (s_tdata[DATA_WIDTH-1:0]),
        .setpoint (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .drive    (m_tdata)
    );

endmodule

`default_nettype wire

[sv/pidfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module pidfd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a stalled result beat holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one sample in flight: input closes right after a beat is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again while a sample is in flight");

    // a new result only comes out of a busy block
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a sample in flight");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind pid_filtered_derivative_top pidfd_checker u_pidfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/pid_filtered_derivative_top_tb.sv]
`timescale 1ns / 1ps

module pid_filtered_derivative_top_tb;

    localparam int DW           = 16;
    localparam int TDATA_W      = ((2*DW+7)/8)*8;
    localparam int IDX_W        = pidfd_pkg::CFG_IDX_W;
    localparam int CDATA_W      = pidfd_pkg::CFG_DATA_W;
    localparam int OUT_W        = pidfd_pkg::DRIVE_W;
    localparam int DRAIN_CYCLES = 80;
    localparam int BLOCK_ITEMS  = 120;
    localparam int WINDUP_ITEMS = 24;
    localparam int BACKOFF_ITEMS = 8;
    localparam int HOLD_CYCLES  = 1500;

    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;
    localparam longint DELTA_CAP = 64'sd1 << 30;

    // indexes past the register file; writes to them must be ignored
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [IDX_W-1:0]         idx;
        logic [CDATA_W-1:0]       data;
        logic signed [DW-1:0]     meas;
        logic signed [DW-1:0]     setp;
        logic                     known;
        logic signed [OUT_W-1:0]  drive;
    } plan_row_t;

    localparam int PLAN_LEN = 38;

    logic aclk;
    logic aresetn = 1'b0;

    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CDATA_W-1:0]    cfg_data  = '0;

    pid_filtered_derivative_top #(.DATA_WIDTH(DW)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // controller shadow: registers and loop state
    pidfd_pkg::cfg_t                      ctl_cfg;
    logic signed [pidfd_pkg::SUM_W-1:0]   integ_acc  = '0;
    logic signed [pidfd_pkg::SLOPE_W-1:0] slope_acc  = '0;
    logic signed [DW:0]                   last_err   = '0;

    logic signed [OUT_W-1:0]   drive_q[$];
    int                        faults       = 0;
    int                        snd_idle_pct = 0;
    int                        rcv_idle_pct = 0;
    logic                      hold_kick    = 1'b0;
    int                        stall_left   = 0;

    plan_row_t plan [PLAN_LEN] = '{
        // reset gains: every drive is zero
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh0000, 1'b1, 32'sd0},
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 32'sd0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 1'b1, 32'sd0},
        '{ROW_SAMPLE, '0, '0, 16'shFFFF, 16'sh0001, 1'b1, 32'sd0},
        // unity proportional gain, upper data bits are junk
        '{ROW_WRITE, pidfd_pkg::REG_GAIN_PROP, 32'hABCD_0100, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sd1000, 1'b1, 32'sd1000},
        '{ROW_SAMPLE, '0, '0, 16'sd1000, 16'sh8000, 1'b1, -32'sd33768},
        // all gains at positive full scale, longest period
        '{ROW_WRITE, pidfd_pkg::REG_GAIN_PROP,      32'h0000_7FFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_GAIN_INTEG,     32'hFFFF_7FFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_GAIN_DERIV,     32'h5A5A_7FFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_SAMPLE_PERIOD,  32'h1234_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_INTEGRAL_LIMIT, 32'h8000_0000, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh5555, 16'shAAAA, 1'b0, '0},
        // negative full scale, slowest filter, tight clamp
        '{ROW_WRITE, pidfd_pkg::REG_GAIN_PROP,      32'h0000_8000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_GAIN_INTEG,     32'h0000_8000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_GAIN_DERIV,     32'h0000_8000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_FILTER_TIME,    32'hFFFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_INTEGRAL_LIMIT, 32'h8000_03E8, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'shAAAA, 16'sh5555, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh7FFF, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh7FFF, 1'b0, '0},
        // zero divisor: slope must hold
        '{ROW_WRITE, pidfd_pkg::REG_SAMPLE_PERIOD,  32'h0000_0000, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_FILTER_TIME,    32'hFFFF_0000, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sd1234, -16'sd1234, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0},
        // writes past the register file change nothing
        '{ROW_WRITE, CFG_IDX_SPARE_A,               32'hFFFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_WRITE, CFG_IDX_SPARE_B,               32'hFFFF_FFFF, '0, '0, 1'b0, '0},
        // tiny divisor: slope saturates
        '{ROW_WRITE, pidfd_pkg::REG_SAMPLE_PERIOD,  32'h0000_0001, '0, '0, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh0001, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0001, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0},
        '{ROW_WRITE, pidfd_pkg::REG_FILTER_TIME,    32'h0000_0001, '0, '0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh0000, 16'sh0000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh8000, 16'sh8000, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'sh4321, 16'shC0DE, 1'b0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(4_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint limit_to(input longint v, input longint lo, input longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void store_reg(input logic [IDX_W-1:0] idx,
                                      input logic [CDATA_W-1:0] data);
        case (idx)
            pidfd_pkg::REG_GAIN_PROP:
                ctl_cfg.gain_prop      = data[pidfd_pkg::GAIN_W-1:0];
            pidfd_pkg::REG_GAIN_INTEG:
                ctl_cfg.gain_integ     = data[pidfd_pkg::GAIN_W-1:0];
            pidfd_pkg::REG_GAIN_DERIV:
                ctl_cfg.gain_deriv     = data[pidfd_pkg::GAIN_W-1:0];
            pidfd_pkg::REG_SAMPLE_PERIOD:
                ctl_cfg.sample_period  = data[pidfd_pkg::TIME_W-1:0];
            pidfd_pkg::REG_FILTER_TIME:
                ctl_cfg.filter_time    = data[pidfd_pkg::TIME_W-1:0];
            pidfd_pkg::REG_INTEGRAL_LIMIT:
                ctl_cfg.integral_limit = data[pidfd_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // one control step: advance integral, filtered slope and last error; return drive
    function automatic logic signed [OUT_W-1:0] pid_drive(input logic signed [DW-1:0] meas,
                                                         input logic signed [DW-1:0] setp);
        longint err, den, delta, num, a, bc, x, res, lim;
        logic   inexact;
        err = longint'(setp) - longint'(meas);
        den = longint'(ctl_cfg.sample_period) + longint'(ctl_cfg.filter_time);

        integ_acc = 32'(limit_to(longint'(integ_acc) + err, S32_MIN, S32_MAX));
        if (ctl_cfg.integral_limit != 0) begin
            lim = longint'(ctl_cfg.integral_limit);
            integ_acc = 32'(limit_to(longint'(integ_acc), -lim, lim));
        end

        // no divide when period plus filter time is zero: slope holds
        if (den != 0) begin
            delta = limit_to(err - longint'(last_err), -DELTA_CAP, DELTA_CAP);
            num = longint'(ctl_cfg.filter_time) * longint'(slope_acc) + (delta <<< 32);
            slope_acc = 32'(limit_to(num / den, S32_MIN, S32_MAX));
        end

        // Q.24 total = a * 2^16 + bc, rounded toward zero down to an integer
        a  = longint'($signed(ctl_cfg.gain_prop)) * err;
        bc = longint'($signed(ctl_cfg.gain_integ)) * longint'(integ_acc)
             * longint'(ctl_cfg.sample_period)
           + longint'($signed(ctl_cfg.gain_deriv)) * longint'(slope_acc);
        x = a + (bc >>> 16);
        inexact = (bc[15:0] != 0) || (x[7:0] != 0);
        res = x >>> 8;
        if (x < 0 && inexact) res += 1;

        last_err = 17'(err);
        return 32'(limit_to(res, S32_MIN, S32_MAX));
    endfunction

    task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        store_reg(idx, data);
    endtask

    task automatic send_sample(input logic signed [DW-1:0] meas, input logic signed [DW-1:0] setp,
                               input logic known, input logic signed [OUT_W-1:0] drive_typed);
        logic signed [OUT_W-1:0] drive_calc;
        while ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {setp, meas};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        drive_calc = pid_drive(meas, setp);
        drive_q.push_back(known ? drive_typed : drive_calc);
    endtask

    // hold the input off and let every pending drive come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (drive_q.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [CDATA_W-1:0] pick_gain();
        logic [CDATA_W-1:0] junk;
        junk = $urandom;
        case ($urandom_range(7))
            0: return {junk[31:16], 16'h7FFF};
            1: return {junk[31:16], 16'h8000};
            2: return {junk[31:16], 16'h0000};
            3: return {junk[31:16], 16'h0100};
            default: return junk;
        endcase
    endfunction

    function automatic logic [CDATA_W-1:0] pick_time();
        logic [CDATA_W-1:0] junk;
        junk = $urandom;
        case ($urandom_range(5))
            0: return {junk[31:16], 16'h0000};
            1: return {junk[31:16], 16'h0001};
            2: return {junk[31:16], 16'hFFFF};
            3: return {junk[31:16], 16'($urandom_range(1, 2000))};
            default: return junk;
        endcase
    endfunction

    function automatic logic [CDATA_W-1:0] pick_limit();
        logic [CDATA_W-1:0] junk;
        junk = $urandom;
        case ($urandom_range(5))
            0: return {junk[31], 31'd0};
            1: return {junk[31], 31'($urandom_range(1, 1000))};
            2: return {junk[31], 31'($urandom_range(1, 2000000))};
            3: return {junk[31], 31'h7FFF_FFFF};
            default: return junk;
        endcase
    endfunction

    task automatic shuffle_regs();
        put_reg(pidfd_pkg::REG_GAIN_PROP, pick_gain());
        put_reg(pidfd_pkg::REG_GAIN_INTEG, pick_gain());
        put_reg(pidfd_pkg::REG_GAIN_DERIV, pick_gain());
        put_reg(pidfd_pkg::REG_SAMPLE_PERIOD, pick_time());
        put_reg(pidfd_pkg::REG_FILTER_TIME, pick_time());
        put_reg(pidfd_pkg::REG_INTEGRAL_LIMIT, pick_limit());
        if ($urandom_range(3) == 0) put_reg(CFG_IDX_SPARE_A, $urandom);
        if ($urandom_range(3) == 0) put_reg(CFG_IDX_SPARE_B, $urandom);
    endtask

    always @(posedge aclk) begin
        if (hold_kick) begin
            stall_left = HOLD_CYCLES;
            hold_kick  = 1'b0;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin : drive_check
        logic signed [OUT_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (drive_q.size() == 0) begin
                $error("drive: result with nothing pending, actual %0d", $signed(m_tdata));
                faults++;
            end else begin
                want = drive_q.pop_front();
                if (m_tdata !== want) begin
                    $error("drive: expected %0d, actual %0d", want, $signed(m_tdata));
                    faults++;
                end
            end
        end
    end

    initial begin : stimulus
        logic signed [DW-1:0] meas_v, setp_v, target_v;
        ctl_cfg = '{gain_prop: '0, gain_integ: '0, gain_deriv: '0,
                    sample_period: pidfd_pkg::SAMPLE_PERIOD_RST, filter_time: '0,
                    integral_limit: '0};
        target_v = '0;
        meas_v   = '0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        snd_idle_pct = 29;
        rcv_idle_pct = 82;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_drained();
                put_reg(plan[i].idx, plan[i].data);
            end else begin
                cfg_valid <= 1'b0;
                send_sample(plan[i].meas, plan[i].setp, plan[i].known, plan[i].drive);
            end
        end

        // push the integral hard one way, then back off a little
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        wait_drained();
        put_reg(pidfd_pkg::REG_GAIN_PROP, 32'h0000_0100);
        put_reg(pidfd_pkg::REG_GAIN_INTEG, 32'h0000_7FFF);
        put_reg(pidfd_pkg::REG_GAIN_DERIV, 32'h0000_0000);
        put_reg(pidfd_pkg::REG_SAMPLE_PERIOD, 32'h0000_FFFF);
        put_reg(pidfd_pkg::REG_FILTER_TIME, 32'h0000_0000);
        put_reg(pidfd_pkg::REG_INTEGRAL_LIMIT, 32'h0000_0000);
        cfg_valid <= 1'b0;
        repeat (WINDUP_ITEMS) send_sample(16'sh8000, 16'sh7FFF, 1'b0, '0);
        repeat (BACKOFF_ITEMS) send_sample(16'sh7FFF, 16'sh8000, 1'b0, '0);

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 82 : 0;
            rcv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 29 : 0;
            for (int blk = 0; blk < 4; blk++) begin
                wait_drained();
                shuffle_regs();
                cfg_valid <= 1'b0;
                if (ph == 2 && blk == 1) hold_kick = 1'b1;
                repeat (BLOCK_ITEMS) begin
                    case ($urandom_range(7))
                        0, 1, 2: begin
                            meas_v = 16'($urandom);
                            setp_v = 16'($urandom);
                        end
                        3, 4, 5: begin
                            // track a target with small measurement wander
                            setp_v = target_v;
                            meas_v = target_v + 16'($urandom_range(0, 64)) - 16'sd32;
                        end
                        6: begin
                            meas_v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                            setp_v = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                        end
                        default: begin
                            // step change of the target
                            target_v = 16'($urandom);
                            setp_v   = target_v;
                        end
                    endcase
                    send_sample(meas_v, setp_v, 1'b0, '0);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
